/* rtl/dkbs_pkg.sv */
// ----------------------------------------------------------------------------
// dkbs_pkg
// Shared types and constants for the distinct-key batch stagger block.
// ----------------------------------------------------------------------------
package dkbs_pkg;

   localparam int KEY_W         = 31;
   localparam int DELAY_W       = 31;
   localparam int BSIZE_W       = 5;
   localparam int STEP_W        = 16;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 16;

   localparam int KEY_SLOTS_DEF   = 16;
   localparam int MAX_BATCHES_DEF = 4096;

   localparam logic [BSIZE_W-1:0] BATCH_SIZE_RST = 5'd4;
   localparam logic [STEP_W-1:0]  DELAY_MS_RST   = 16'd1000;

   localparam logic [CSR_IDX_W-1:0] CSR_BATCH_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_MS   = 1'b1;

   localparam logic [DELAY_W-1:0] DELAY_MAX = 31'h7FFF_FFFF;

   // decision made by the key set for one transaction
   typedef struct packed {
      logic close_batch;   // new key met a full batch: next batch opens
      logic opens;         // transaction is the first of its batch
   } batch_evt_type;

endpackage

/* rtl/dkbs_key_set.sv */
// ----------------------------------------------------------------------------
// dkbs_key_set
// Distinct keys of the current batch: parallel membership check, fill count,
// and the close/open decision for each transaction.
// ----------------------------------------------------------------------------
module dkbs_key_set
   import dkbs_pkg::*;
#(
   parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [KEY_W-1:0]   key,
   input  logic               first,
   input  logic [BSIZE_W-1:0] batch_size,
   output batch_evt_type      evt
);

   localparam int CNT_W = $clog2(KEY_SLOTS + 1);
   localparam int IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
   localparam int SZ_W  = (CNT_W > BSIZE_W) ? CNT_W : BSIZE_W;

   // entries below the fill count are valid; store is payload only
   logic [KEY_W-1:0] key_store_ff [KEY_SLOTS];
   logic [CNT_W-1:0] key_count_ff;
   logic [CNT_W-1:0] key_count_in;

   logic [CNT_W-1:0] count_cur;
   logic [SZ_W-1:0]  eff_size;
   logic             hit;
   logic             full;
   logic [IDX_W-1:0] slot;

   assign count_cur = first ? '0 : key_count_ff;

   always_comb begin
      if (batch_size == '0) begin
         eff_size = SZ_W'(1);
      end else if (SZ_W'(batch_size) > SZ_W'(KEY_SLOTS)) begin
         eff_size = SZ_W'(KEY_SLOTS);
      end else begin
         eff_size = SZ_W'(batch_size);
      end
   end

   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if ((CNT_W'(i) < count_cur) && (key_store_ff[i] == key)) begin
            hit = 1'b1;
         end
      end
   end

   assign full            = SZ_W'(count_cur) >= eff_size;
   assign evt.close_batch = !hit && full;
   assign evt.opens       = !hit && (full || (count_cur == '0));
   assign slot            = evt.close_batch ? '0 : count_cur[IDX_W-1:0];

   always_comb begin
      if (hit) begin
         key_count_in = count_cur;
      end else if (evt.close_batch) begin
         key_count_in = CNT_W'(1);
      end else begin
         key_count_in = count_cur + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= '0;
      end else if (step) begin
         key_count_ff <= key_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && !hit) begin
         key_store_ff[slot] <= key;
      end
   end

endmodule

/* rtl/dkbs_stagger.sv */
// ----------------------------------------------------------------------------
// dkbs_stagger
// Batch counter and delay accumulator, both saturating.
// ----------------------------------------------------------------------------
module dkbs_stagger
   import dkbs_pkg::*;
#(
   parameter int MAX_BATCHES = MAX_BATCHES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic                           first,
   input  batch_evt_type                  evt,
   input  logic [STEP_W-1:0]              delay_ms,
   output logic [$clog2(MAX_BATCHES)-1:0] batch_index,
   output logic [DELAY_W-1:0]             start_delay,
   output logic                           immediate
);

   localparam int BI_W = $clog2(MAX_BATCHES);
   localparam logic [BI_W-1:0] INDEX_TOP = BI_W'(MAX_BATCHES - 1);

   logic [BI_W-1:0]    batch_counter_ff;
   logic [BI_W-1:0]    batch_counter_in;
   logic [DELAY_W-1:0] delay_acc_ff;
   logic [DELAY_W-1:0] delay_acc_in;

   logic [BI_W-1:0]    counter_cur;
   logic [DELAY_W-1:0] acc_cur;
   logic [DELAY_W:0]   acc_sum;

   assign counter_cur = first ? '0 : batch_counter_ff;
   assign acc_cur     = first ? '0 : delay_acc_ff;
   assign acc_sum     = {1'b0, acc_cur} + (DELAY_W + 1)'(delay_ms);

   always_comb begin
      batch_counter_in = counter_cur;
      delay_acc_in     = acc_cur;
      if (evt.close_batch) begin
         if (counter_cur != INDEX_TOP) begin
            batch_counter_in = counter_cur + BI_W'(1);
         end
         delay_acc_in = acc_sum[DELAY_W] ? DELAY_MAX : acc_sum[DELAY_W-1:0];
      end
   end

   assign batch_index = batch_counter_in;
   assign start_delay = delay_acc_in;
   assign immediate   = (batch_counter_in == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_counter_ff <= '0;
         delay_acc_ff     <= '0;
      end else if (step) begin
         batch_counter_ff <= batch_counter_in;
         delay_acc_ff     <= delay_acc_in;
      end
   end

endmodule

/* rtl/distinct_key_batch_stagger_top.sv */
// ----------------------------------------------------------------------------
// distinct_key_batch_stagger_top
// Assigns each request to a batch of at most batch_size distinct keys and
// gives it a staggered start delay.
// ----------------------------------------------------------------------------
// One request transaction per cycle, sustained while rsp_tready does not hold the
// result register. The input register loads on the accepting edge and the result
// register on the edge at which the stage advances, which back-pressure on the
// result stream can delay; rsp_tvalid rises once the result register has loaded. The
// cycle budget is set by the key membership check: a parallel compare of the
// key against every filled slot of the key store, plus the saturating
// counter and 31-bit delay add, all between the two registers. The key set
// and counters update on the same edge that loads the result register, so
// consecutive requests see each other's effects without a bubble. A request
// whose tuser flag (first_of_call) is set starts a new call: key set, batch
// counter and delay are cleared before it is handled. CSR writes are meant
// to happen while the block holds no request.
// ----------------------------------------------------------------------------
module distinct_key_batch_stagger_top
   import dkbs_pkg::*;
#(
   parameter int KEY_SLOTS   = KEY_SLOTS_DEF,
   parameter int MAX_BATCHES = MAX_BATCHES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // [30:0] owner_key, [31] zero pad
   input  logic                  req_tuser,   // [0] first_of_call
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // batch_index (low bits), then start_delay (31 bits), zero padded to bytes
   output logic [((($clog2(MAX_BATCHES) + DELAY_W) + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser,   // [0] immediate, [1] opens_batch
   // CSR write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int BI_W  = $clog2(MAX_BATCHES);
   localparam int RSP_W = (((BI_W + DELAY_W) + 7) / 8) * 8;
   localparam int PAD_W = RSP_W - BI_W - DELAY_W;

   // ---------------------------------------------------------------- CSRs
   logic [BSIZE_W-1:0] batch_size_ff;
   logic [STEP_W-1:0]  delay_ms_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_size_ff <= BATCH_SIZE_RST;
         delay_ms_ff   <= DELAY_MS_RST;
      end else if (csr_we) begin
         unique case (csr_idx)
            CSR_BATCH_SIZE: batch_size_ff <= csr_wdata[BSIZE_W-1:0];
            CSR_DELAY_MS:   delay_ms_ff   <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- input register
   logic             s1_valid_ff;
   logic             s1_valid_in;
   logic [KEY_W-1:0] s1_key_ff;
   logic             s1_first_ff;
   logic             req_accept;
   logic             advance;

   // the stage moves when the result register is free or being drained
   assign advance    = s1_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   assign s1_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_key_ff   <= req_tdata[KEY_W-1:0];
         s1_first_ff <= req_tuser;
      end
   end

   // ---------------------------------------------------------------- batch logic
   batch_evt_type      evt;
   logic [BI_W-1:0]    batch_index;
   logic [DELAY_W-1:0] start_delay;
   logic               immediate;

   dkbs_key_set #(
      .KEY_SLOTS (KEY_SLOTS)
   ) u_key_set (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .key        (s1_key_ff),
      .first      (s1_first_ff),
      .batch_size (batch_size_ff),
      .evt        (evt)
   );

   dkbs_stagger #(
      .MAX_BATCHES (MAX_BATCHES)
   ) u_stagger (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .first       (s1_first_ff),
      .evt         (evt),
      .delay_ms    (delay_ms_ff),
      .batch_index (batch_index),
      .start_delay (start_delay),
      .immediate   (immediate)
   );

   // ---------------------------------------------------------------- result register
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [BI_W-1:0]    rsp_index_ff;
   logic [DELAY_W-1:0] rsp_delay_ff;
   logic               rsp_imm_ff;
   logic               rsp_opens_ff;

   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_index_ff <= batch_index;
         rsp_delay_ff <= start_delay;
         rsp_imm_ff   <= immediate;
         rsp_opens_ff <= evt.opens;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_delay_ff, rsp_index_ff};
   assign rsp_tuser  = {rsp_opens_ff, rsp_imm_ff};

   // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
   // a new call always starts batch 0 with no delay and opens it
   a_first_opens: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_first_ff) |=>
         (rsp_opens_ff && rsp_imm_ff && rsp_index_ff == '0 && rsp_delay_ff == '0))
      else $error("first transaction of a call did not open batch 0");

   // within a call the batch index never goes back
   a_index_mono: assert property (@(posedge clock) disable iff (reset)
      (advance && !s1_first_ff && rsp_valid_ff) |=>
         (rsp_index_ff >= $past(rsp_index_ff)))
      else $error("batch index decreased within a call");

   // within a call the start delay never goes back
   a_delay_mono: assert property (@(posedge clock) disable iff (reset)
      (advance && !s1_first_ff && rsp_valid_ff) |=>
         (rsp_delay_ff >= $past(rsp_delay_ff)))
      else $error("start delay decreased within a call");
`endif

endmodule
